// ===== hdl/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

  localparam int MAX_BYTES = 6;
  localparam int COUNT_W = 3;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [15:0] MASK_ASCII = 16'hFF80;
  localparam logic [15:0] MASK_TWO = 16'hF800;
  localparam logic [15:0] MASK_SURR = 16'hFC00;
  localparam logic [15:0] HIGH_SURR = 16'hD800;
  localparam logic [15:0] LOW_SURR = 16'hDC00;
  localparam logic [7:0] LEAD_TWO = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR = 8'hF0;
  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [5:0] CONT_BITS = 6'h3F;

  // One encoded item: the bytes it produces, oldest in slot zero.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MAX_BYTES-1:0][7:0] bytes;
  } job_t;

  function automatic logic [2:0][7:0] three_bytes(input logic [15:0] u);
    logic [2:0][7:0] b;
    b[0] = LEAD_THREE | {4'h0, u[15:12]};
    b[1] = CONT_MARK | {2'b00, u[11:6] & CONT_BITS};
    b[2] = CONT_MARK | {2'b00, u[5:0] & CONT_BITS};
    return b;
  endfunction

endpackage

// ===== hdl/utf16_to_utf8_encoder.sv =====
// UTF-16 to UTF-8 encoder: top level joining front end, job queue and serializer.
//
// Input channel: present one UTF-16 code unit on code_unit with push high;
// the transfer happens on a clock edge where push is high and full is low.
// A zero unit ends a string and yields a zero byte.
// Result channel: while empty is low, out_byte and run_last show the oldest
// byte; it transfers on an edge where pop is high. run_last marks the final
// byte caused by one code unit (a held high surrogate causes no byte until
// the next unit arrives).
// The first byte of an item passes through the job queue, the current-job
// register and the result register before it becomes visible.
// Throughput: one byte per cycle while the receiver pops, set by the single
// result register; an item yields zero to six bytes, three for most BMP
// units, and a new unit is taken every cycle while the job queue has room.
// Reset: clears the held surrogate, the queue and the result register.
// A stalled receiver holds the current byte; the queue fills, then full rises.
module utf16_to_utf8_encoder #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        run_last
);

  u16u8_pkg::job_t front_job;
  u16u8_pkg::job_t head_job;
  logic            job_push;
  logic            head_pop;
  logic            queue_empty;

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .queue_full (full),
    .code_unit  (code_unit),
    .job_push   (job_push),
    .job        (front_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (front_job),
    .rd_en  (head_pop),
    .rd_job (head_job),
    .full   (full),
    .empty  (queue_empty)
  );

  u16u8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_job   (head_job),
    .queue_pop   (head_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .run_last    (run_last)
  );

endmodule

// ===== hdl/u16u8_front.sv =====
// Front end: takes code units, tracks a held high surrogate and builds byte jobs.
module u16u8_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                queue_full,
  input  logic [15:0]         code_unit,
  output logic                job_push,
  output u16u8_pkg::job_t     job
);

  logic        held_valid;
  logic        held_valid_next;
  logic [15:0] held_surrogate;
  logic [15:0] held_surrogate_next;

  logic             accept;
  logic             is_low;
  logic             is_high;
  logic [1:0]       cur_count;
  logic [2:0][7:0]  cur_bytes;
  logic [2:0][7:0]  held_bytes;
  logic [4:0]       plane;

  assign accept = push && !queue_full;
  assign is_low = (code_unit & u16u8_pkg::MASK_SURR) == u16u8_pkg::LOW_SURR;
  assign is_high = (code_unit & u16u8_pkg::MASK_SURR) == u16u8_pkg::HIGH_SURR;
  assign held_bytes = u16u8_pkg::three_bytes(held_surrogate);
  // The supplementary plane is the high surrogate's top four payload bits plus one.
  assign plane = {1'b0, held_surrogate[9:6]} + 5'd1;

  always_comb begin
    cur_bytes = '0;
    cur_count = 2'd0;
    if (code_unit == 16'h0000) begin
      cur_count = 2'd1;
    end else if ((code_unit & u16u8_pkg::MASK_ASCII) == 16'h0000) begin
      cur_bytes[0] = code_unit[7:0];
      cur_count = 2'd1;
    end else if ((code_unit & u16u8_pkg::MASK_TWO) == 16'h0000) begin
      cur_bytes[0] = u16u8_pkg::LEAD_TWO | {3'b000, code_unit[10:6]};
      cur_bytes[1] = u16u8_pkg::CONT_MARK | {2'b00, code_unit[5:0]};
      cur_count = 2'd2;
    end else if (!is_high) begin
      cur_bytes = u16u8_pkg::three_bytes(code_unit);
      cur_count = 2'd3;
    end
  end

  always_comb begin
    job = '0;
    held_valid_next = held_valid;
    held_surrogate_next = held_surrogate;
    if (held_valid && is_low) begin
      job.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'b00000, plane[4:2]};
      job.bytes[1] = u16u8_pkg::CONT_MARK | {2'b00, plane[1:0], held_surrogate[5:2]};
      job.bytes[2] = u16u8_pkg::CONT_MARK | {2'b00, held_surrogate[1:0], code_unit[9:6]};
      job.bytes[3] = u16u8_pkg::CONT_MARK | {2'b00, code_unit[5:0]};
      job.count = u16u8_pkg::COUNT_W'(4);
      held_valid_next = 1'b0;
    end else begin
      if (held_valid) begin
        job.bytes[2:0] = held_bytes;
        job.bytes[5:3] = cur_bytes;
        job.count = u16u8_pkg::COUNT_W'(3) + u16u8_pkg::COUNT_W'(cur_count);
      end else begin
        job.bytes[2:0] = cur_bytes;
        job.count = u16u8_pkg::COUNT_W'(cur_count);
      end
      held_valid_next = is_high;
      held_surrogate_next = code_unit;
    end
  end

  // A high surrogate with nothing held produces no bytes and needs no queue slot.
  assign job_push = accept && (job.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_surrogate <= '0;
    end else if (accept) begin
      held_valid <= held_valid_next;
      held_surrogate <= held_surrogate_next;
    end
  end

endmodule

// ===== hdl/u16u8_queue.sv =====
// Small job queue that decouples the front end from the byte serializer.
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  u16u8_pkg::job_t wr_job,
  input  logic            rd_en,
  output u16u8_pkg::job_t rd_job,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u16u8_pkg::job_t  slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign full = fill == CNT_W'(DEPTH);
  assign empty = fill == '0;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/u16u8_back.sv =====
// Back end: feeds the result register one byte per cycle unless stalled.
module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            queue_empty,
  input  u16u8_pkg::job_t queue_job,
  output logic            queue_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            run_last
);

  u16u8_pkg::job_t               cur;
  logic                          cur_valid;
  logic [u16u8_pkg::COUNT_W-1:0] idx;
  logic                          out_valid;

  logic out_load;
  logic emit;
  logic cur_last;

  // The result register can take a new byte when it is free or being popped.
  assign out_load = !out_valid || pop;
  assign emit = cur_valid && out_load;
  assign cur_last = idx == (cur.count - u16u8_pkg::COUNT_W'(1));
  assign queue_pop = (!cur_valid || (emit && cur_last)) && !queue_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (queue_pop) begin
      cur <= queue_job;
    end
    if (emit) begin
      out_byte <= cur.bytes[idx];
      run_last <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (queue_pop) begin
        cur_valid <= 1'b1;
        idx <= '0;
      end else if (emit) begin
        cur_valid <= !cur_last;
        idx <= idx + u16u8_pkg::COUNT_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/u16u8_checker.sv =====
// Port-level checks for the UTF-16 to UTF-8 encoder, bound to the top level.
module u16u8_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic [15:0] code_unit,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte,
  input logic        run_last
);

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered right after reset");

  // A waiting byte holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_last)))
    else $error("waiting byte changed or vanished");

  // Bytes of one sequence stream without a gap once the first is taken.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !run_last) |=> !empty)
    else $error("gap inside a byte sequence");

  // A lead byte of a multi-byte sequence is never the final byte.
  a_lead_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_byte[7:6] == 2'b11) |-> !run_last)
    else $error("sequence ends on a lead byte");

  // The zero byte only comes from a string terminator, which always ends its run.
  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_byte == 8'h00) |-> run_last)
    else $error("zero byte not marked final");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .code_unit (code_unit),
  .empty     (empty),
  .pop       (pop),
  .out_byte  (out_byte),
  .run_last  (run_last)
);

// ===== tb/tb_utf16_to_utf8_encoder.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 encoder.
`timescale 1ns / 100ps

module tb_utf16_to_utf8_encoder;

  localparam int RANDOM_UNITS = 355;
  localparam int QUIET_TAIL = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } utf8_byte_t;

  // Tracks the surrogate state and the UTF-8 bytes still owed by the block.
  class utf8_scoreboard;
    utf8_byte_t  pending_bytes[$];
    logic [15:0] held_unit;
    logic        held_valid;
    int          mismatches;

    function new();
      held_unit = '0;
      held_valid = 1'b0;
      mismatches = 0;
    endfunction

    function void add_byte(logic [7:0] value);
      utf8_byte_t b;
      b.value = value;
      b.last = 1'b0;
      pending_bytes.push_back(b);
    endfunction

    function void add_three(logic [15:0] u);
      add_byte(u16u8_pkg::LEAD_THREE | {4'h0, u[15:12]});
      add_byte(u16u8_pkg::CONT_MARK | {2'b00, u[11:6]});
      add_byte(u16u8_pkg::CONT_MARK | {2'b00, u[5:0]});
    endfunction

    // Works out the bytes caused by one accepted code unit.
    function void encode_unit(logic [15:0] u);
      logic [20:0] cp;
      int          first;
      first = pending_bytes.size();
      if (held_valid) begin
        held_valid = 1'b0;
        if ((u & u16u8_pkg::MASK_SURR) == u16u8_pkg::LOW_SURR) begin
          // The offsets of both halves simply concatenate above 0x10000.
          cp = 21'h10000 + {1'b0, held_unit[9:0], u[9:0]};
          held_unit = '0;
          add_byte(u16u8_pkg::LEAD_FOUR | {5'b00000, cp[20:18]});
          add_byte(u16u8_pkg::CONT_MARK | {2'b00, cp[17:12]});
          add_byte(u16u8_pkg::CONT_MARK | {2'b00, cp[11:6]});
          add_byte(u16u8_pkg::CONT_MARK | {2'b00, cp[5:0]});
          pending_bytes[pending_bytes.size() - 1].last = 1'b1;
          return;
        end
        add_three(held_unit);
        held_unit = '0;
      end
      if (u == 16'h0000) begin
        add_byte(8'h00);
      end else if ((u & u16u8_pkg::MASK_ASCII) == 16'h0000) begin
        add_byte(u[7:0]);
      end else if ((u & u16u8_pkg::MASK_TWO) == 16'h0000) begin
        add_byte(u16u8_pkg::LEAD_TWO | {3'b000, u[10:6]});
        add_byte(u16u8_pkg::CONT_MARK | {2'b00, u[5:0]});
      end else if ((u & u16u8_pkg::MASK_SURR) == u16u8_pkg::HIGH_SURR) begin
        held_unit = u;
        held_valid = 1'b1;
      end else begin
        add_three(u);
      end
      if (pending_bytes.size() > first) begin
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_byte(logic [7:0] value, logic last);
      utf8_byte_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h (run_last %b)", value, last));
      end else begin
        want = pending_bytes.pop_front();
        if (value !== want.value) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h", value, want.value));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                    last, want.last, want.value));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] code_unit = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;

  utf8_scoreboard sb = new();
  bit             idle_on = 1'b1;
  int             cycle_count = 0;

  utf16_to_utf8_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .code_unit (code_unit),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** utf16_to_utf8_encoder: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Presents one unit and holds it until the transfer happens.
  task send_unit(logic [15:0] u);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push = 1'b1;
    code_unit = u;
    do @(posedge clk); while (full);
    sb.encode_unit(u);
  endtask

  function automatic logic [15:0] random_unit(int kind);
    logic [15:0] u;
    if (kind < 42) begin
      u = 16'($urandom_range(1, 16'h007F));
    end else if (kind < 54) begin
      u = 16'($urandom_range(16'h0080, 16'h07FF));
    end else if (kind < 70) begin
      u = 16'($urandom_range(16'h0800, 16'hFFFF));
      // Steer out of the surrogate block; those are picked on purpose below.
      if ((u & u16u8_pkg::MASK_TWO) == u16u8_pkg::HIGH_SURR) u = u ^ 16'h2000;
    end else if (kind < 76) begin
      u = u16u8_pkg::HIGH_SURR | 16'($urandom_range(0, 1023));
    end else if (kind < 82) begin
      u = u16u8_pkg::LOW_SURR | 16'($urandom_range(0, 1023));
    end else if (kind < 88) begin
      u = 16'h0000;
    end else begin
      u = 16'($urandom_range(0, 16'hFFFF));
    end
    return u;
  endfunction

  initial begin
    logic [15:0] directed_units[$];
    int          kind;
    int          sent;
    directed_units = '{16'h0041, 16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
                       16'hD7FF, 16'hE000, 16'hFFFF, 16'hD800, 16'hDC00, 16'hDBFF,
                       16'hDFFF, 16'hDC00, 16'hD800, 16'hD801, 16'hDC05, 16'hDBC0,
                       16'h0000, 16'hD955, 16'h0041, 16'hDA00, 16'h07FF, 16'hDB00,
                       16'hFFFF};
    wait (!rst);
    foreach (directed_units[i]) send_unit(directed_units[i]);
    sent = 0;
    while (sent < RANDOM_UNITS) begin
      if (sent >= RANDOM_UNITS - QUIET_TAIL) idle_on = 1'b0;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_unit(u16u8_pkg::HIGH_SURR | 16'($urandom_range(0, 1023)));
        send_unit(u16u8_pkg::LOW_SURR | 16'($urandom_range(0, 1023)));
        sent += 2;
      end else begin
        send_unit(random_unit($urandom_range(0, 99)));
        sent++;
      end
    end
    @(negedge clk);
    push = 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** utf16_to_utf8_encoder: PASSED **");
    end else begin
      $display("** utf16_to_utf8_encoder: FAILED **");
    end
    $finish;
  end

  // Result side: takes bytes with random stall bursts while idling is enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) sb.check_byte(out_byte, run_last);
    end
  end

endmodule

// ===== files.f =====
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_encoder.sv
hdl/u16u8_checker.sv
tb/tb_utf16_to_utf8_encoder.sv
